// ----- design/fct_pkg.sv -----
// fct_pkg: shared types, codes and defaults of the fragment context table
// used by every file of the design folder, no dependencies
package fct_pkg;

  localparam int MAX_CONTEXTS_DEF      = 8;
  localparam int FRAGS_PER_CONTEXT_DEF = 8;
  localparam int RESULT_CAP            = 64;
  localparam int CAP_W                 = 7;
  localparam int HELD_W                = 27;
  localparam int IN_TDATA_W            = 136;
  localparam int OUT_TDATA_W           = 48;

  localparam logic [3:0] ACT_DELIVERED   = 4'd0;
  localparam logic [3:0] ACT_DITCHED     = 4'd1;
  localparam logic [3:0] ACT_HELD        = 4'd2;
  localparam logic [3:0] ACT_DROP_FULL   = 4'd3;
  localparam logic [3:0] ACT_BL_DELIVER  = 4'd4;
  localparam logic [3:0] ACT_BL_DISCARD  = 4'd5;
  localparam logic [3:0] ACT_EVICT_REL   = 4'd6;
  localparam logic [3:0] ACT_EXPIRE_REL  = 4'd7;
  localparam logic [3:0] ACT_NOTHING     = 4'd8;

  localparam logic [1:0] MODE_WAIT    = 2'd0;
  localparam logic [1:0] MODE_DISCARD = 2'd1;
  localparam logic [1:0] MODE_HANDLE  = 2'd2;

  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_LIMIT   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOK, ST_INIT, ST_DMX, ST_ACT,
    ST_LRD, ST_LEM, ST_TICK, ST_TNXT, ST_FIN
  } state_t;

  typedef struct packed {
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [7:0]  protocol;
    logic [15:0] ident;
    logic [1:0]  demux_kind;
    logic [15:0] demux_handle;
    logic [15:0] frag_ref;
    logic [10:0] header_size;
  } item_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] client_handle;
    logic [15:0] frag_ref;
    logic [10:0] header_size;
    logic [2:0]  context_slot;
  } result_t;

  typedef struct packed {
    logic push;
    logic fin;
  } res_ctl_t;

endpackage

// ----- design/fct_held_store.sv -----
// fct_held_store: memory of held fragment descriptors, one row per context
// and list place; registered read. depends on fct_pkg
module fct_held_store #(
  parameter int DEPTH = fct_pkg::MAX_CONTEXTS_DEF * fct_pkg::FRAGS_PER_CONTEXT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [fct_pkg::HELD_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [fct_pkg::HELD_W-1:0] rd_data
);

  logic [fct_pkg::HELD_W-1:0] mem [DEPTH];
  logic [fct_pkg::HELD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/fct_result_out.sv -----
// fct_result_out: one pending result plus the output register; marks last
// and caps results per item. depends on fct_pkg
module fct_result_out (
  input  logic                              clk,
  input  logic                              rst_n,
  input  fct_pkg::res_ctl_t                 ctl,
  input  fct_pkg::result_t                  res,
  output logic                              can_take,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fct_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [3:0]                        out_tuser,
  output logic                              out_tlast
);

  fct_pkg::result_t           pend_r, obuf_r;
  logic                       pend_v_r, out_v_r, last_r;
  logic [fct_pkg::CAP_W-1:0]  cnt_r;
  logic                       take_out;

  assign take_out = out_v_r && out_tready;
  // closing an item always loads the output register, so it needs that register free
  assign can_take = !out_v_r || out_tready || (!pend_v_r && !ctl.fin);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (take_out) begin
        out_v_r <= 1'b0;
      end
      if (ctl.fin && can_take) begin
        out_v_r  <= 1'b1;
        pend_v_r <= 1'b0;
        cnt_r    <= '0;
      end else if (ctl.push && can_take && cnt_r != fct_pkg::CAP_W'(fct_pkg::RESULT_CAP)) begin
        cnt_r    <= cnt_r + 1'b1;
        pend_v_r <= 1'b1;
        if (pend_v_r) begin
          out_v_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin && can_take) begin
      last_r <= 1'b1;
      if (pend_v_r) begin
        obuf_r <= pend_r;
      end else begin
        obuf_r <= '{action: fct_pkg::ACT_NOTHING, default: '0};
      end
    end else if (ctl.push && can_take && cnt_r != fct_pkg::CAP_W'(fct_pkg::RESULT_CAP)) begin
      pend_r <= res;
      if (pend_v_r) begin
        obuf_r <= pend_r;
        last_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = obuf_r.action;
  assign out_tlast  = last_r;
  assign out_tdata  = {2'b00, obuf_r.context_slot, obuf_r.header_size,
                       obuf_r.frag_ref, obuf_r.client_handle};

endmodule

// ----- design/fragment_context_table_core.sv -----
// fragment_context_table_core: top level, context registers and sequencer
// depends on fct_pkg, fct_held_store, fct_result_out
//
// channel | direction | transfer contents
// in_     | slave     | tuser func, tdata fragment key, demux, descriptor
// out_    | master    | tuser action, tdata handle, descriptor, slot; tlast
// cfg_    | write     | index 0 timeout_ticks, 1 active_context_limit
//
// one item at a time: after the input transfer a fragment is looked up, set up
// anew on a miss, and walks a descriptor list on an eviction, restart or backlog
// flush, with a result pushed per released or flushed descriptor; a tick visits
// every context and releases the descriptors of each expired one, each read
// going through the registered descriptor memory.
// reset is synchronous, no clearing pass; a stalled output holds the sequencer.
module fragment_context_table_core #(
  parameter int MAX_CONTEXTS      = fct_pkg::MAX_CONTEXTS_DEF,
  parameter int FRAGS_PER_CONTEXT = fct_pkg::FRAGS_PER_CONTEXT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // source_addr, dest_addr, protocol, ident, demux_kind, demux_handle,
  // frag_ref, header_size, zero fill
  input  logic [fct_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              in_tuser,   // func
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // client_handle, out_frag_ref, out_header_size, context_slot, zero fill
  output logic [fct_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic [3:0]                        out_tuser,  // action
  output logic                              out_tlast,  // last
  input  logic                              cfg_wr_en,
  input  logic                              cfg_addr,
  input  logic [15:0]                       cfg_wr_data
);

  localparam int SW    = $clog2(MAX_CONTEXTS);
  localparam int CW    = $clog2(FRAGS_PER_CONTEXT + 1);
  localparam int NW    = $clog2(MAX_CONTEXTS + 1);
  localparam int DEPTH = MAX_CONTEXTS * FRAGS_PER_CONTEXT;
  localparam int AW    = $clog2(DEPTH);

  logic [15:0] timeout_r;
  logic [3:0]  limit_r;

  logic          valid_r  [MAX_CONTEXTS];
  logic [31:0]   src_r    [MAX_CONTEXTS];
  logic [31:0]   dst_r    [MAX_CONTEXTS];
  logic [7:0]    proto_r  [MAX_CONTEXTS];
  logic [15:0]   ident_r  [MAX_CONTEXTS];
  logic [1:0]    mode_r   [MAX_CONTEXTS];
  logic [15:0]   handle_r [MAX_CONTEXTS];
  logic [15:0]   remain_r [MAX_CONTEXTS];
  logic [SW-1:0] rec_r    [MAX_CONTEXTS];
  logic [CW-1:0] cnt_r    [MAX_CONTEXTS];

  fct_pkg::state_t st_r, st_nxt, after_r, after_nxt;
  fct_pkg::item_t  it_r;
  logic [1:0]      kind_r;
  logic            func_r;
  logic [SW-1:0]   slot_r, slot_nxt, op_slot;
  logic [CW-1:0]   idx_r, idx_nxt, n_r, n_nxt;
  logic [3:0]      lact_r, lact_nxt;
  logic            lrel_r, lrel_nxt;

  // strobes into the context registers
  logic do_refresh, do_init, do_clr, do_cnt_clr, do_mode, do_cnt_inc, do_tick;
  logic mem_we;

  fct_pkg::res_ctl_t ctl;
  fct_pkg::result_t  res;
  logic              can_take;

  logic [15:0] eff_to;
  logic [NW-1:0] lim, nvalid;
  logic          hit, free_f, vict_f;
  logic [SW-1:0] hit_s, free_s, vict_s;
  logic [AW-1:0] addr;
  logic [fct_pkg::HELD_W-1:0] rd_data;

  assign eff_to    = (timeout_r == '0) ? 16'd1 : timeout_r;
  assign in_tready = (st_r == fct_pkg::ST_IDLE);

  always_comb begin
    if (limit_r == '0) begin
      lim = NW'(1);
    end else if (int'(limit_r) > MAX_CONTEXTS) begin
      lim = NW'(MAX_CONTEXTS);
    end else begin
      lim = NW'(limit_r);
    end
  end

  // parallel key match, most recent free slot, least recent valid slot
  always_comb begin
    hit = 1'b0; hit_s = '0;
    free_f = 1'b0; free_s = '0;
    vict_f = 1'b0; vict_s = '0;
    nvalid = '0;
    for (int s = 0; s < MAX_CONTEXTS; s++) begin
      if (valid_r[s]) begin
        nvalid = nvalid + 1'b1;
      end
      if (!hit && valid_r[s] && src_r[s] == it_r.source_addr && dst_r[s] == it_r.dest_addr &&
          proto_r[s] == it_r.protocol && ident_r[s] == it_r.ident) begin
        hit = 1'b1; hit_s = SW'(s);
      end
      if (!valid_r[s] && (!free_f || rec_r[s] < rec_r[free_s])) begin
        free_f = 1'b1; free_s = SW'(s);
      end
      if (valid_r[s] && (!vict_f || rec_r[s] > rec_r[vict_s])) begin
        vict_f = 1'b1; vict_s = SW'(s);
      end
    end
  end

  always_comb begin
    st_nxt = st_r; after_nxt = after_r; slot_nxt = slot_r;
    idx_nxt = idx_r; n_nxt = n_r; lact_nxt = lact_r; lrel_nxt = lrel_r;
    op_slot = slot_r;
    do_refresh = 1'b0; do_init = 1'b0; do_clr = 1'b0; do_cnt_clr = 1'b0;
    do_mode = 1'b0; do_cnt_inc = 1'b0; do_tick = 1'b0; mem_we = 1'b0;
    ctl = '0;
    res = '0;
    addr = AW'(int'(slot_r) * FRAGS_PER_CONTEXT + int'(idx_r));
    unique case (st_r)
      fct_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          slot_nxt = '0;
          st_nxt = in_tuser ? fct_pkg::ST_TICK : fct_pkg::ST_LOOK;
        end
      end
      fct_pkg::ST_LOOK: begin
        if (hit) begin
          op_slot = hit_s; slot_nxt = hit_s; do_refresh = 1'b1;
          st_nxt = fct_pkg::ST_DMX;
        end else if (nvalid >= lim) begin
          slot_nxt = vict_s; n_nxt = cnt_r[vict_s]; idx_nxt = '0;
          lact_nxt = fct_pkg::ACT_EVICT_REL; lrel_nxt = 1'b1;
          after_nxt = fct_pkg::ST_INIT; st_nxt = fct_pkg::ST_LRD;
        end else begin
          slot_nxt = free_s; st_nxt = fct_pkg::ST_INIT;
        end
      end
      fct_pkg::ST_INIT: begin
        do_init = 1'b1; st_nxt = fct_pkg::ST_DMX;
      end
      fct_pkg::ST_DMX: begin
        st_nxt = fct_pkg::ST_ACT;
        if (kind_r != fct_pkg::MODE_WAIT) begin
          if (mode_r[slot_r] != fct_pkg::MODE_WAIT) begin
            // demux info while demux set: kill and recreate in place
            n_nxt = cnt_r[slot_r]; idx_nxt = '0;
            lact_nxt = fct_pkg::ACT_EVICT_REL; lrel_nxt = 1'b1;
            after_nxt = fct_pkg::ST_INIT; st_nxt = fct_pkg::ST_LRD;
          end else begin
            do_mode = 1'b1;
          end
        end
      end
      fct_pkg::ST_ACT: begin
        res.frag_ref = it_r.frag_ref;
        res.header_size = it_r.header_size;
        res.context_slot = 3'(slot_r);
        addr = AW'(int'(slot_r) * FRAGS_PER_CONTEXT + int'(cnt_r[slot_r]));
        case (mode_r[slot_r])
          fct_pkg::MODE_DISCARD: res.action = fct_pkg::ACT_DITCHED;
          fct_pkg::MODE_HANDLE: begin
            res.action = fct_pkg::ACT_DELIVERED;
            res.client_handle = handle_r[slot_r];
          end
          default: begin
            if (int'(cnt_r[slot_r]) < FRAGS_PER_CONTEXT) begin
              res.action = fct_pkg::ACT_HELD;
            end else begin
              res.action = fct_pkg::ACT_DROP_FULL;
            end
          end
        endcase
        ctl.push = 1'b1;
        if (can_take) begin
          if (res.action == fct_pkg::ACT_HELD) begin
            mem_we = 1'b1; do_cnt_inc = 1'b1;
          end
          if (kind_r != fct_pkg::MODE_WAIT) begin
            n_nxt = cnt_r[slot_r]; idx_nxt = '0; lrel_nxt = 1'b0;
            lact_nxt = (mode_r[slot_r] == fct_pkg::MODE_HANDLE) ?
                       fct_pkg::ACT_BL_DELIVER : fct_pkg::ACT_BL_DISCARD;
            after_nxt = fct_pkg::ST_FIN; st_nxt = fct_pkg::ST_LRD;
          end else begin
            st_nxt = fct_pkg::ST_FIN;
          end
        end
      end
      fct_pkg::ST_LRD: begin
        if (idx_r == n_r) begin
          if (lrel_r) begin
            do_clr = 1'b1;
          end else begin
            do_cnt_clr = 1'b1;
          end
          st_nxt = after_r;
        end else begin
          st_nxt = fct_pkg::ST_LEM;
        end
      end
      fct_pkg::ST_LEM: begin
        res.action = lact_r;
        res.client_handle = (lact_r == fct_pkg::ACT_BL_DELIVER) ? handle_r[slot_r] : 16'd0;
        res.frag_ref = rd_data[26:11];
        res.header_size = rd_data[10:0];
        res.context_slot = 3'(slot_r);
        ctl.push = 1'b1;
        if (can_take) begin
          idx_nxt = CW'(idx_r + 1'b1);
          st_nxt = fct_pkg::ST_LRD;
        end
      end
      fct_pkg::ST_TICK: begin
        st_nxt = fct_pkg::ST_TNXT;
        if (valid_r[slot_r]) begin
          do_tick = 1'b1;
          if (remain_r[slot_r] <= 16'd1) begin
            n_nxt = cnt_r[slot_r]; idx_nxt = '0;
            lact_nxt = fct_pkg::ACT_EXPIRE_REL; lrel_nxt = 1'b1;
            after_nxt = fct_pkg::ST_TNXT; st_nxt = fct_pkg::ST_LRD;
          end
        end
      end
      fct_pkg::ST_TNXT: begin
        if (int'(slot_r) == MAX_CONTEXTS - 1) begin
          st_nxt = fct_pkg::ST_FIN;
        end else begin
          slot_nxt = SW'(slot_r + 1'b1);
          st_nxt = fct_pkg::ST_TICK;
        end
      end
      fct_pkg::ST_FIN: begin
        ctl.fin = 1'b1;
        if (can_take) begin
          st_nxt = fct_pkg::ST_IDLE;
        end
      end
      default: st_nxt = fct_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= fct_pkg::ST_IDLE;
      after_r   <= fct_pkg::ST_IDLE;
      timeout_r <= 16'd60;
      limit_r   <= 4'd5;
    end else begin
      st_r    <= st_nxt;
      after_r <= after_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          fct_pkg::CFG_TIMEOUT: timeout_r <= cfg_wr_data;
          fct_pkg::CFG_LIMIT:   limit_r   <= cfg_wr_data[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
    idx_r  <= idx_nxt;
    n_r    <= n_nxt;
    lact_r <= lact_nxt;
    lrel_r <= lrel_nxt;
    if (in_tvalid && in_tready) begin
      // source_addr sits in the lowest bits of tdata but in the highest bits of the struct
      it_r   <= {in_tdata[31:0], in_tdata[63:32], in_tdata[71:64], in_tdata[87:72],
                 in_tdata[89:88], in_tdata[105:90], in_tdata[121:106], in_tdata[132:122]};
      func_r <= in_tuser;
      kind_r <= (in_tdata[89:88] == 2'd3) ? fct_pkg::MODE_WAIT : in_tdata[89:88];
    end
  end

  // control part of the context table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < MAX_CONTEXTS; s++) begin
        valid_r[s]  <= 1'b0;
        mode_r[s]   <= fct_pkg::MODE_WAIT;
        remain_r[s] <= '0;
        rec_r[s]    <= SW'(s);
        cnt_r[s]    <= '0;
      end
    end else begin
      if (do_refresh || do_init) begin
        for (int s = 0; s < MAX_CONTEXTS; s++) begin
          if (rec_r[s] < rec_r[op_slot]) begin
            rec_r[s] <= rec_r[s] + 1'b1;
          end
        end
        rec_r[op_slot]    <= '0;
        remain_r[op_slot] <= eff_to;
      end
      if (do_init) begin
        valid_r[op_slot] <= 1'b1;
        mode_r[op_slot]  <= fct_pkg::MODE_WAIT;
        cnt_r[op_slot]   <= '0;
      end
      if (do_clr) begin
        valid_r[op_slot] <= 1'b0;
        cnt_r[op_slot]   <= '0;
      end
      if (do_cnt_clr) begin
        cnt_r[op_slot] <= '0;
      end
      if (do_cnt_inc) begin
        cnt_r[op_slot] <= cnt_r[op_slot] + 1'b1;
      end
      if (do_mode) begin
        mode_r[op_slot] <= kind_r;
      end
      if (do_tick && remain_r[op_slot] != '0) begin
        remain_r[op_slot] <= remain_r[op_slot] - 1'b1;
      end
    end
  end

  // key and handle payload
  always_ff @(posedge clk) begin
    if (do_init) begin
      src_r[op_slot]    <= it_r.source_addr;
      dst_r[op_slot]    <= it_r.dest_addr;
      proto_r[op_slot]  <= it_r.protocol;
      ident_r[op_slot]  <= it_r.ident;
      handle_r[op_slot] <= '0;
    end
    if (do_mode && kind_r == fct_pkg::MODE_HANDLE && !func_r) begin
      handle_r[op_slot] <= it_r.demux_handle;
    end
  end

  fct_held_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_held (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (addr),
    .wr_data ({it_r.frag_ref, it_r.header_size}),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  fct_result_out u_res (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .res        (res),
    .can_take   (can_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
